### hdl/dfs_pkg.sv
// Shared types and constants for the depth-first path finder.
// No dependencies; imported by every module of the block.
package dfs_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int VERT_W       = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CFG_W        = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int KIND_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VERTEX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_VERTEX = 2'd2;

   localparam logic [VERT_W-1:0] VCOUNT_RESET = VERT_W'(MAX_VERTICES);
   localparam logic [VERT_W-1:0] START_RESET  = VERT_W'(1);
   localparam logic [VERT_W-1:0] TARGET_RESET = VERT_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_VISIT   = 2'd0,
      KIND_PATH    = 2'd1,
      KIND_UNREACH = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_START,
      SRC_FOUND,
      SRC_CUR
   } src_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_SEARCH,
      ST_TAIL,
      ST_PATH
   } state_type;

   typedef struct packed {
      logic     store_row;
      logic     init_walk;
      logic     push;
      logic     pop;
      logic     cur_target;
      logic     emit;
      src_type  src;
      kind_type kind;
      logic     last;
   } dfs_cmd_type;

   typedef struct packed {
      logic row_last;
      logic start_ok;
      logic found;
      logic cur_is_start;
      logic target_ok;
      logic can_emit;
   } dfs_stat_type;

endpackage

### hdl/dfs_ctrl.sv
// Walk sequencer: loads rows, then steps the search, path trace and result beats.
// Depends on dfs_pkg; drives dfs_datapath through dfs_cmd_type.
module dfs_ctrl
   import dfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  dfs_stat_type stat,
   output dfs_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd.store_row  = 1'b0;
      cmd.init_walk  = 1'b0;
      cmd.push       = 1'b0;
      cmd.pop        = 1'b0;
      cmd.cur_target = 1'b0;
      cmd.emit       = 1'b0;
      cmd.src        = SRC_NONE;
      cmd.kind       = KIND_VISIT;
      cmd.last       = 1'b0;
      req_stall      = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall     = 1'b0;
            cmd.store_row = req_valid;
            if (req_valid && stat.row_last) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (!stat.start_ok) begin
               cmd.init_walk = 1'b1;
               state_in      = ST_TAIL;
            end else if (stat.can_emit) begin
               cmd.init_walk = 1'b1;
               cmd.emit      = 1'b1;
               cmd.src       = SRC_START;
               cmd.kind      = KIND_VISIT;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.found) begin
               if (stat.can_emit) begin
                  cmd.push = 1'b1;
                  cmd.emit = 1'b1;
                  cmd.src  = SRC_FOUND;
                  cmd.kind = KIND_VISIT;
               end
            end else if (stat.cur_is_start) begin
               state_in = ST_TAIL;
            end else begin
               cmd.pop = 1'b1;
            end
         end
         ST_TAIL: begin
            if (stat.target_ok) begin
               cmd.cur_target = 1'b1;
               state_in       = ST_PATH;
            end else if (stat.can_emit) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_NONE;
               cmd.kind = KIND_UNREACH;
               cmd.last = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_PATH: begin
            if (stat.can_emit) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_CUR;
               cmd.kind = KIND_PATH;
               cmd.last = stat.cur_is_start;
               if (stat.cur_is_start) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.pop = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

### hdl/dfs_datapath.sv
// Graph store, config registers, visited/parent state, neighbour search and result register.
// Depends on dfs_pkg; steered by dfs_ctrl via dfs_cmd_type.
module dfs_datapath
   import dfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [MAX_VERTICES-1:0] req_adjacency_row,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_data,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [KIND_W-1:0]       rsp_kind,
   output logic [VERT_W-1:0]       rsp_vertex,
   output logic [VERT_W-1:0]       rsp_from_vertex,
   output logic                    rsp_last,
   input  dfs_cmd_type             cmd,
   output dfs_stat_type            stat
);

   logic [VERT_W-1:0]       vcount_ff;
   logic [VERT_W-1:0]       start_ff;
   logic [VERT_W-1:0]       target_ff;
   logic [MAX_VERTICES-1:0] adj_ff [MAX_VERTICES];
   logic [VERT_W-1:0]       row_cnt_ff;
   logic [VERT_W-1:0]       row_cnt_in;
   logic [MAX_VERTICES-1:0] visited_ff;
   logic [VERT_W-1:0]       parent_ff [MAX_VERTICES];
   logic [VERT_W-1:0]       cur_ff;
   logic [VERT_W-1:0]       cur_in;

   logic                    rsp_valid_ff;
   logic [KIND_W-1:0]       rsp_kind_ff;
   logic [VERT_W-1:0]       rsp_vertex_ff;
   logic [VERT_W-1:0]       rsp_from_ff;
   logic                    rsp_last_ff;

   logic [VERT_W-1:0]       n_eff;
   logic [VERT_W-1:0]       row_next;
   logic [IDX_W-1:0]        cur_idx;
   logic [IDX_W-1:0]        start_idx;
   logic [IDX_W-1:0]        target_idx;
   logic [MAX_VERTICES-1:0] nbr;
   logic [MAX_VERTICES-1:0] cand;
   logic                    found;
   logic [IDX_W-1:0]        found_idx;
   logic [VERT_W-1:0]       found_vertex;
   logic [VERT_W-1:0]       out_vertex;
   logic [VERT_W-1:0]       out_from;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_RESET;
         start_ff  <= START_RESET;
         target_ff <= TARGET_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_VERTEX_COUNT:  vcount_ff <= VERT_W'(csr_data);
            CSR_START_VERTEX:  start_ff  <= VERT_W'(csr_data);
            CSR_TARGET_VERTEX: target_ff <= VERT_W'(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      if (vcount_ff == '0) begin
         n_eff = VERT_W'(1);
      end else if (vcount_ff > VERT_W'(MAX_VERTICES)) begin
         n_eff = VERT_W'(MAX_VERTICES);
      end else begin
         n_eff = vcount_ff;
      end
   end

   // Row loading
   assign row_next = row_cnt_ff + VERT_W'(1);

   always_comb begin
      row_cnt_in = row_cnt_ff;
      if (cmd.store_row) begin
         row_cnt_in = (row_next >= n_eff) ? '0 : row_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_ff[i] <= '0;
         end
      end else begin
         row_cnt_ff <= row_cnt_in;
         if (cmd.store_row) begin
            adj_ff[row_cnt_ff[IDX_W-1:0]] <= req_adjacency_row;
         end
      end
   end

   // Neighbour search: lower triangle mirrored, lowest unvisited vertex in use
   assign cur_idx    = IDX_W'(cur_ff - VERT_W'(1));
   assign start_idx  = IDX_W'(start_ff - VERT_W'(1));
   assign target_idx = IDX_W'(target_ff - VERT_W'(1));

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         if (IDX_W'(j) <= cur_idx) begin
            nbr[j] = adj_ff[cur_idx][j];
         end else begin
            nbr[j] = adj_ff[j][cur_idx];
         end
         cand[j] = nbr[j] && !visited_ff[j] && (VERT_W'(j) < n_eff);
      end
   end

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
         if (cand[j]) begin
            found     = 1'b1;
            found_idx = IDX_W'(j);
         end
      end
   end

   assign found_vertex = VERT_W'(found_idx) + VERT_W'(1);

   // Walk state
   always_comb begin
      cur_in = cur_ff;
      if (cmd.init_walk) begin
         cur_in = start_ff;
      end else if (cmd.push) begin
         cur_in = found_vertex;
      end else if (cmd.pop) begin
         cur_in = parent_ff[cur_idx];
      end else if (cmd.cur_target) begin
         cur_in = target_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.push) begin
         parent_ff[found_idx] <= cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
      end else if (cmd.init_walk) begin
         visited_ff <= stat.start_ok ? (MAX_VERTICES'(1) << start_idx) : '0;
      end else if (cmd.push) begin
         visited_ff[found_idx] <= 1'b1;
      end
   end

   // Result register
   always_comb begin
      case (cmd.src)
         SRC_START: begin
            out_vertex = start_ff;
            out_from   = '0;
         end
         SRC_FOUND: begin
            out_vertex = found_vertex;
            out_from   = cur_ff;
         end
         SRC_CUR: begin
            out_vertex = cur_ff;
            out_from   = '0;
         end
         default: begin
            out_vertex = '0;
            out_from   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.kind;
         rsp_vertex_ff <= out_vertex;
         rsp_from_ff   <= out_from;
         rsp_last_ff   <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_vertex      = rsp_vertex_ff;
   assign rsp_from_vertex = rsp_from_ff;
   assign rsp_last        = rsp_last_ff;

   // Status
   assign stat.row_last     = row_next >= n_eff;
   assign stat.start_ok     = (start_ff != '0) && (start_ff <= n_eff);
   assign stat.found        = found;
   assign stat.cur_is_start = cur_ff == start_ff;
   assign stat.target_ok    = (target_ff != '0) && (target_ff <= n_eff)
                              && visited_ff[target_idx];
   assign stat.can_emit     = !rsp_valid_ff || !rsp_stall;

endmodule

### hdl/dfs_path_finder_top.sv
// Channel  | Ports                                   | Beat taken when
// req      | req_valid, req_stall, req_adjacency_row | req_valid && !req_stall
// rsp      | rsp_valid, rsp_stall, rsp_kind, ...      | rsp_valid && !rsp_stall
// csr      | csr_write_en, csr_index, csr_data       | csr_write_en
//
// Rows are taken one a cycle; the last row of a graph starts the walk and req_stall
// stays high until its last beat is in the result register.
// Walk: send the start; push to the lowest unvisited neighbour (a visit beat) or pop
// to the parent until the start has none; check the target; send an unreachable beat
// or the path from target to start. Beats wait while the result register is stalled.
// Reset is synchronous; graph store, visited marks and config return to defaults.
// Depends on dfs_pkg, dfs_ctrl and dfs_datapath.
module dfs_path_finder_top
   import dfs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MAX_VERTICES-1:0] req_adjacency_row,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [KIND_W-1:0]       rsp_kind,
   output logic [VERT_W-1:0]       rsp_vertex,
   output logic [VERT_W-1:0]       rsp_from_vertex,
   output logic                    rsp_last,
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]        csr_data
);

   dfs_cmd_type  cmd;
   dfs_stat_type stat;

   dfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dfs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_adjacency_row (req_adjacency_row),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_vertex        (rsp_vertex),
      .rsp_from_vertex   (rsp_from_vertex),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .stat              (stat)
   );

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.can_emit)
      else $error("result written over a stalled beat");

   a_push_found: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> stat.found)
      else $error("push without a candidate neighbour");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.store_row, cmd.init_walk, cmd.push, cmd.pop, cmd.cur_target}))
      else $error("conflicting datapath commands");

   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !cmd.emit)
      else $error("result beat while loading rows");

endmodule
